// ----- hdl/ldrf_pkg.sv -----
package ldrf_pkg;

	// default sizing of the position counter and of the byte alphabet
	localparam int POS_BITS_DEF      = 16;
	localparam int ALPHABET_SIZE_DEF = 256;

	// string bytes are fixed at eight bits
	localparam int BYTE_W = 8;

	// apb register file: one 32-bit register at byte address 0
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int REG_IDX_W  = 1;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_END_CHAR = 1'b0;

	// newline terminates a string after reset
	localparam logic [BYTE_W-1:0] END_CHAR_RESET = 8'd10;

	// tracker state seen from the top level
	typedef struct packed {
		logic s1_valid;
		logic s1_emit;
	} ldrf_stat_t;

endpackage

// ----- hdl/ldrf_if.sv -----
// byte stream into the block
interface ldrf_in_if;
	logic                       valid;
	logic                       ready;
	logic [ldrf_pkg::BYTE_W-1:0] data_byte;
	logic                       end_of_string;

	modport source(output valid, output data_byte, output end_of_string, input ready);
	modport sink(input valid, input data_byte, input end_of_string, output ready);
endinterface

// one result per string
interface ldrf_out_if #(
	parameter int POS_BITS = ldrf_pkg::POS_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic [POS_BITS:0]   best_length;
	logic [POS_BITS-1:0] best_start;
	logic                overflow;

	modport source(output valid, output best_length, output best_start, output overflow,
		input ready);
	modport sink(input valid, input best_length, input best_start, input overflow,
		output ready);
endinterface

// ----- hdl/ldrf_ram.sv -----
module ldrf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read returning the old data on a collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/ldrf_cfg.sv -----
module ldrf_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ldrf_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [ldrf_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [ldrf_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	output logic [ldrf_pkg::BYTE_W-1:0]       end_char
);

	logic [ldrf_pkg::BYTE_W-1:0]    end_char_q;
	logic [ldrf_pkg::REG_IDX_W-1:0] reg_idx;
	logic                           wr_xfer;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ldrf_pkg::APB_ADDR_W-1:2];
	assign wr_xfer = psel && penable && pwrite && pready;

	// register write in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_char_q <= ldrf_pkg::END_CHAR_RESET;
		end else if (wr_xfer && reg_idx == ldrf_pkg::REG_END_CHAR) begin
			end_char_q <= pwdata[ldrf_pkg::BYTE_W-1:0];
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			ldrf_pkg::REG_END_CHAR: begin
				prdata = ldrf_pkg::APB_DATA_W'(end_char_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign end_char = end_char_q;

endmodule

// ----- hdl/ldrf_track.sv -----
module ldrf_track #(
	parameter int POS_BITS      = ldrf_pkg::POS_BITS_DEF,
	parameter int ALPHABET_SIZE = ldrf_pkg::ALPHABET_SIZE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ldrf_pkg::BYTE_W-1:0] end_char,
	ldrf_in_if.sink                     stream,
	ldrf_out_if.source                  result,
	output ldrf_pkg::ldrf_stat_t        stat
);

	localparam int SYM_W = $clog2(ALPHABET_SIZE);
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

	// constant table folding a byte value into the alphabet
	function automatic logic [SYM_W-1:0] fold_byte(input logic [ldrf_pkg::BYTE_W-1:0] b);
		logic [SYM_W-1:0] r;
		int               k;
		r = '0;
		k = 0;
		for (int i = 0; i < 2**ldrf_pkg::BYTE_W; i++) begin
			if (b == ldrf_pkg::BYTE_W'(i)) begin
				r = SYM_W'(k);
			end
			k = (k == ALPHABET_SIZE - 1) ? 0 : k + 1;
		end
		return r;
	endfunction

	// stage 1 pipeline registers
	logic                valid_s1;
	logic                term_s1;
	logic                last_s1;
	logic [SYM_W-1:0]    sym_s1;
	logic                hit_s1;
	logic [POS_BITS-1:0] fwd_pos_s1;

	// per-string state
	logic [POS_BITS-1:0]      pos_q;
	logic [POS_BITS-1:0]      win_q;
	logic [POS_BITS:0]        best_len_q;
	logic [POS_BITS-1:0]      best_start_q;
	logic                     ovf_q;
	logic [ALPHABET_SIZE-1:0] seen_q;

	// output register
	logic                out_valid_q;
	logic [POS_BITS:0]   out_len_q;
	logic [POS_BITS-1:0] out_start_q;
	logic                out_ovf_q;

	logic                sym_in;
	logic [SYM_W-1:0]    sym_acc;
	logic                acc;
	logic                out_free;
	logic                emit;
	logic                go;
	logic                at_max;
	logic                take;
	logic [POS_BITS-1:0] rd_data;
	logic [POS_BITS-1:0] prev;
	logic                dup;
	logic [POS_BITS-1:0] win_nx;
	logic [POS_BITS:0]   len;
	logic                better;
	logic [POS_BITS:0]   blen_nx;
	logic [POS_BITS-1:0] bstart_nx;
	logic                ovf_nx;

	// fold the byte into the alphabet
	assign sym_acc = fold_byte(stream.data_byte);
	assign sym_in  = (sym_acc == sym_s1);

	// handshake: stage 1 stalls only when it owes a result and the output is full
	assign out_free     = !out_valid_q || result.ready;
	assign emit         = term_s1 || last_s1;
	assign go           = valid_s1 && (!emit || out_free);
	assign stream.ready = !valid_s1 || go;
	assign acc          = stream.valid && stream.ready;

	// last-seen position table
	ldrf_ram #(
		.WIDTH(POS_BITS),
		.DEPTH(ALPHABET_SIZE)
	) u_last_seen (
		.clk  (clk),
		.we   (take),
		.waddr(sym_s1),
		.wdata(pos_q),
		.re   (acc),
		.raddr(sym_acc),
		.rdata(rd_data)
	);

	// sliding window update for the byte in stage 1
	always_comb begin
		at_max    = (pos_q == POS_MAX);
		take      = go && !term_s1 && !at_max;
		prev      = hit_s1 ? fwd_pos_s1 : rd_data;
		dup       = seen_q[sym_s1] && (prev >= win_q);
		win_nx    = dup ? prev + POS_BITS'(1) : win_q;
		len       = {1'b0, pos_q} - {1'b0, win_nx} + (POS_BITS+1)'(1);
		better    = len > best_len_q;
		blen_nx   = (take && better) ? len : best_len_q;
		bstart_nx = (take && better) ? win_nx : best_start_q;
		ovf_nx    = ovf_q || (!term_s1 && at_max);
	end

	// stage 1 capture, with forwarding of a write to the same byte value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			term_s1    <= (stream.data_byte == end_char);
			last_s1    <= stream.end_of_string;
			sym_s1     <= sym_acc;
			hit_s1     <= take && sym_in;
			fwd_pos_s1 <= pos_q;
		end
	end

	// per-string state, cleared when the string ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			win_q        <= '0;
			best_len_q   <= '0;
			best_start_q <= '0;
			ovf_q        <= 1'b0;
			seen_q       <= '0;
		end else if (go) begin
			if (emit) begin
				pos_q        <= '0;
				win_q        <= '0;
				best_len_q   <= '0;
				best_start_q <= '0;
				ovf_q        <= 1'b0;
				seen_q       <= '0;
			end else begin
				if (take) begin
					pos_q          <= pos_q + POS_BITS'(1);
					win_q          <= win_nx;
					seen_q[sym_s1] <= 1'b1;
				end
				best_len_q   <= blen_nx;
				best_start_q <= bstart_nx;
				ovf_q        <= ovf_nx;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			out_len_q   <= blen_nx;
			out_start_q <= bstart_nx;
			out_ovf_q   <= ovf_nx;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.best_length = out_len_q;
	assign result.best_start  = out_start_q;
	assign result.overflow    = out_ovf_q;

	assign stat.s1_valid = valid_s1;
	assign stat.s1_emit  = emit;

endmodule

// ----- hdl/longest_distinct_run_finder_unit.sv -----
// Longest distinct run finder.
// stream: one string byte per transfer (data_byte, end_of_string). A byte equal
//   to the end_char register ends the string and is not counted; end_of_string
//   on any other byte counts the byte and then ends the string.
// result: one transfer per string with best_length and best_start of the
//   earliest longest run of pairwise distinct bytes, and overflow when bytes
//   past position 2^POS_BITS-2 were dropped.
// apb: end_char at byte address 0, newline after reset.
// Throughput: one byte per cycle while stage 1 is not stalled. Each byte does
//   one read-modify-write of the last-seen table (one read port, one write
//   port); a write by the byte just ahead is forwarded into the next one.
// Result path: the ending byte is registered in stage 1 and processed there;
//   its result is then captured in the output register, which drives the
//   result port.
// Reset: all per-string state and the seen bits clear at once; the block takes
//   bytes in the first cycle after reset. Table contents are not cleared.
// Stall: a full output register holds its result; a further string end then
//   holds the processing stage and stream.ready drops until result.ready.
module longest_distinct_run_finder_unit #(
	parameter int POS_BITS      = ldrf_pkg::POS_BITS_DEF,
	parameter int ALPHABET_SIZE = ldrf_pkg::ALPHABET_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ldrf_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ldrf_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ldrf_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	ldrf_in_if.sink                         stream,
	ldrf_out_if.source                      result
);

	localparam logic [POS_BITS+1:0] POS_LIMIT = (POS_BITS+2)'({POS_BITS{1'b1}});

	logic [ldrf_pkg::BYTE_W-1:0] end_char;
	ldrf_pkg::ldrf_stat_t        stat;

	// configuration registers
	ldrf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.end_char(end_char)
	);

	// window tracker and last-seen table
	ldrf_track #(
		.POS_BITS     (POS_BITS),
		.ALPHABET_SIZE(ALPHABET_SIZE)
	) u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.end_char(end_char),
		.stream  (stream),
		.result  (result),
		.stat    (stat)
	);

	// a pending string end must not take a byte while the output is blocked
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.s1_valid && stat.s1_emit && result.valid && !result.ready) |-> !stream.ready)
		else $error("byte taken while a result was blocked");

	// an empty run starts at zero
	a_empty_start: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.best_length == '0) |-> (result.best_start == '0))
		else $error("empty run with nonzero start");

	// the run lies within the usable positions
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |->
		((POS_BITS+2)'(result.best_start) + (POS_BITS+2)'(result.best_length)) <= POS_LIMIT)
		else $error("run extends past the position range");

endmodule
